// ===== sv/ecc_pa_pkg.sv =====
// ----------------------------------------------------------------------------
// ecc_pa_pkg
// shared types, constants and modular helpers for the affine point adder
// ----------------------------------------------------------------------------
`default_nettype none

package ecc_pa_pkg;

    localparam int FIELD_WIDTH = 31;

    localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = FIELD_WIDTH'(2147483647);
    localparam logic [FIELD_WIDTH-1:0] CURVE_A_RESET = '0;

    // configuration register indexes
    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_CURVE_A = 1'b1;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] point_x1;
        logic [FIELD_WIDTH-1:0] point_y1;
        logic [FIELD_WIDTH-1:0] point_x2;
        logic [FIELD_WIDTH-1:0] point_y2;
    } in_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] sum_x;
        logic [FIELD_WIDTH-1:0] sum_y;
    } out_t;

    // datapath operand / destination registers
    typedef enum logic [3:0] {
        SRC_X1,
        SRC_Y1,
        SRC_X2,
        SRC_Y2,
        SRC_A,
        SRC_NUM,
        SRC_DEN,
        SRC_ACC,
        SRC_S,
        SRC_T,
        SRC_ONE
    } src_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_COPY,
        OP_OUT,
        OP_OUT_ZERO
    } op_t;

    typedef struct packed {
        logic go;
        op_t  op;
        src_t src_a;
        src_t src_b;
        src_t dst;
        logic exp_load;
        logic exp_shift;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic same_point;
        logic mod_small;
        logic exp_bit;
    } stat_t;

    // (u + v) mod m for u, v below m
    function automatic logic [FIELD_WIDTH-1:0] add_mod(
        input logic [FIELD_WIDTH-1:0] u,
        input logic [FIELD_WIDTH-1:0] v,
        input logic [FIELD_WIDTH-1:0] m
    );
        logic [FIELD_WIDTH:0] sum;
        logic [FIELD_WIDTH:0] red;
        sum = {1'b0, u} + {1'b0, v};
        red = sum - {1'b0, m};
        return (sum >= {1'b0, m}) ? red[FIELD_WIDTH-1:0] : sum[FIELD_WIDTH-1:0];
    endfunction

    // (u - v) mod m for u, v below m
    function automatic logic [FIELD_WIDTH-1:0] sub_mod(
        input logic [FIELD_WIDTH-1:0] u,
        input logic [FIELD_WIDTH-1:0] v,
        input logic [FIELD_WIDTH-1:0] m
    );
        logic [FIELD_WIDTH:0] wrap;
        wrap = {1'b0, u} + {1'b0, m} - {1'b0, v};
        return (u >= v) ? (u - v) : wrap[FIELD_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/ecc_pa_datapath.sv =====
// ----------------------------------------------------------------------------
// ecc_pa_datapath
// operand registers, modular add/sub and a bit-serial modular multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_pa_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ecc_pa_pkg::cmd_t                 cmd,
    output ecc_pa_pkg::stat_t                     stat,
    input  wire ecc_pa_pkg::in_t                  in_data,
    output ecc_pa_pkg::out_t                      out_data,
    input  wire logic                             cfg_write,
    input  wire logic                             cfg_index,
    input  wire logic [ecc_pa_pkg::FIELD_WIDTH-1:0] cfg_data
);

    localparam int W = ecc_pa_pkg::FIELD_WIDTH;
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

    logic [W-1:0] modulus_reg;
    logic [W-1:0] curve_a_reg;

    logic [W-1:0] x1_reg, y1_reg, x2_reg, y2_reg, a_reg;
    logic [W-1:0] num_reg, den_reg, acc_reg, s_reg, t_reg;
    logic [W-1:0] exp_reg;
    ecc_pa_pkg::out_t out_reg;

    // multiplier state
    logic               mul_busy_reg;
    logic [CW-1:0]      mul_cnt_reg;
    logic [W-1:0]       mu_reg;
    logic [W-1:0]       mv_reg;
    logic [W-1:0]       macc_reg;
    ecc_pa_pkg::src_t   mdst_reg;

    logic [W-1:0] a_val, b_val;
    logic [W-1:0] mstep;
    logic         mul_done;
    logic         wr_en;
    ecc_pa_pkg::src_t wr_dst;
    logic [W-1:0] wr_val;

    function automatic logic [W-1:0] pick(input ecc_pa_pkg::src_t sel,
                                          input logic [W-1:0] x1, input logic [W-1:0] y1,
                                          input logic [W-1:0] x2, input logic [W-1:0] y2,
                                          input logic [W-1:0] a, input logic [W-1:0] num,
                                          input logic [W-1:0] den, input logic [W-1:0] acc,
                                          input logic [W-1:0] s, input logic [W-1:0] t);
        logic [W-1:0] v;
        unique case (sel)
            ecc_pa_pkg::SRC_X1:  v = x1;
            ecc_pa_pkg::SRC_Y1:  v = y1;
            ecc_pa_pkg::SRC_X2:  v = x2;
            ecc_pa_pkg::SRC_Y2:  v = y2;
            ecc_pa_pkg::SRC_A:   v = a;
            ecc_pa_pkg::SRC_NUM: v = num;
            ecc_pa_pkg::SRC_DEN: v = den;
            ecc_pa_pkg::SRC_ACC: v = acc;
            ecc_pa_pkg::SRC_S:   v = s;
            ecc_pa_pkg::SRC_T:   v = t;
            ecc_pa_pkg::SRC_ONE: v = W'(1);
            default:             v = '0;
        endcase
        return v;
    endfunction

    assign a_val = pick(cmd.src_a, x1_reg, y1_reg, x2_reg, y2_reg, a_reg,
                        num_reg, den_reg, acc_reg, s_reg, t_reg);
    assign b_val = pick(cmd.src_b, x1_reg, y1_reg, x2_reg, y2_reg, a_reg,
                        num_reg, den_reg, acc_reg, s_reg, t_reg);

    // msb-first double and add: acc = 2*acc (+ u when the multiplier bit is set)
    always_comb
    begin
        logic [W-1:0] dbl;
        dbl   = ecc_pa_pkg::add_mod(macc_reg, macc_reg, modulus_reg);
        mstep = mv_reg[W-1] ? ecc_pa_pkg::add_mod(dbl, mu_reg, modulus_reg) : dbl;
    end

    assign mul_done = mul_busy_reg && (mul_cnt_reg == LAST_STEP);

    always_comb
    begin
        wr_en  = 1'b0;
        wr_dst = cmd.dst;
        wr_val = a_val;
        if (mul_done)
        begin
            wr_en  = 1'b1;
            wr_dst = mdst_reg;
            wr_val = mstep;
        end
        else if (cmd.go)
        begin
            case (cmd.op)
                ecc_pa_pkg::OP_ADD:
                begin
                    wr_en  = 1'b1;
                    wr_val = ecc_pa_pkg::add_mod(a_val, b_val, modulus_reg);
                end
                ecc_pa_pkg::OP_SUB:
                begin
                    wr_en  = 1'b1;
                    wr_val = ecc_pa_pkg::sub_mod(a_val, b_val, modulus_reg);
                end
                ecc_pa_pkg::OP_COPY:
                begin
                    wr_en  = 1'b1;
                end
                default:
                begin
                    wr_en  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= ecc_pa_pkg::MODULUS_RESET;
            curve_a_reg  <= ecc_pa_pkg::CURVE_A_RESET;
            mul_busy_reg <= 1'b0;
            mul_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == ecc_pa_pkg::CFG_MODULUS)
                    modulus_reg <= cfg_data;
                else
                    curve_a_reg <= cfg_data;
            end
            if (cmd.go && cmd.op == ecc_pa_pkg::OP_MUL)
            begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= '0;
            end
            else if (mul_busy_reg)
            begin
                mul_busy_reg <= !mul_done;
                mul_cnt_reg  <= mul_cnt_reg + CW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.go && cmd.op == ecc_pa_pkg::OP_MUL)
        begin
            mu_reg   <= a_val;
            mv_reg   <= b_val;
            macc_reg <= '0;
            mdst_reg <= cmd.dst;
        end
        else if (mul_busy_reg)
        begin
            mv_reg   <= {mv_reg[W-2:0], 1'b0};
            macc_reg <= mstep;
        end

        if (cmd.go && cmd.op == ecc_pa_pkg::OP_LOAD)
        begin
            x1_reg <= in_data.point_x1;
            y1_reg <= in_data.point_y1;
            x2_reg <= in_data.point_x2;
            y2_reg <= in_data.point_y2;
            a_reg  <= curve_a_reg;
        end
        else if (wr_en)
        begin
            case (wr_dst)
                ecc_pa_pkg::SRC_X1:  x1_reg  <= wr_val;
                ecc_pa_pkg::SRC_Y1:  y1_reg  <= wr_val;
                ecc_pa_pkg::SRC_X2:  x2_reg  <= wr_val;
                ecc_pa_pkg::SRC_Y2:  y2_reg  <= wr_val;
                ecc_pa_pkg::SRC_A:   a_reg   <= wr_val;
                ecc_pa_pkg::SRC_NUM: num_reg <= wr_val;
                ecc_pa_pkg::SRC_DEN: den_reg <= wr_val;
                ecc_pa_pkg::SRC_ACC: acc_reg <= wr_val;
                ecc_pa_pkg::SRC_S:   s_reg   <= wr_val;
                ecc_pa_pkg::SRC_T:   t_reg   <= wr_val;
                default:             ;
            endcase
        end

        if (cmd.exp_load)
            exp_reg <= modulus_reg - W'(2);
        else if (cmd.exp_shift)
            exp_reg <= {1'b0, exp_reg[W-1:1]};

        if (cmd.go && cmd.op == ecc_pa_pkg::OP_OUT)
        begin
            out_reg.sum_x <= t_reg;
            out_reg.sum_y <= num_reg;
        end
        else if (cmd.go && cmd.op == ecc_pa_pkg::OP_OUT_ZERO)
        begin
            out_reg.sum_x <= '0;
            out_reg.sum_y <= '0;
        end
    end

    assign out_data        = out_reg;
    assign stat.mul_done   = mul_done;
    assign stat.same_point = (x1_reg == x2_reg) && (y1_reg == y2_reg);
    assign stat.mod_small  = (modulus_reg < W'(2));
    assign stat.exp_bit    = exp_reg[0];

endmodule

`default_nettype wire

// ===== sv/ecc_pa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecc_pa_ctrl
// sequencer for reduction, slope, fermat inversion and result coordinates
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_pa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output ecc_pa_pkg::cmd_t       cmd,
    input  wire ecc_pa_pkg::stat_t stat
);

    localparam int W = ecc_pa_pkg::FIELD_WIDTH;
    localparam int RW = $clog2(W);
    localparam logic [RW-1:0] LAST_ROUND = RW'(W - 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK,
        ST_RED_X1, ST_RED_Y1, ST_RED_X2, ST_RED_Y2, ST_RED_A, ST_BRANCH,
        ST_DBL_SQ, ST_DBL_N1, ST_DBL_N2, ST_DBL_N3, ST_DBL_D,
        ST_CH_N, ST_CH_D,
        ST_INV_INIT, ST_INV_MUL, ST_INV_SQ, ST_SLOPE,
        ST_X3_SQ, ST_X3_S1, ST_X3_S2, ST_Y3_D, ST_Y3_M, ST_Y3_S,
        ST_WRITE
    } state_t;

    state_t        state_reg, state_next;
    logic          issued_reg, issued_next;
    logic [RW-1:0] rnd_reg, rnd_next;
    logic          out_valid_reg, out_valid_next;

    ecc_pa_pkg::op_t  op;
    ecc_pa_pkg::src_t sa, sb, sd;
    logic             step_done;

    // operation per state
    always_comb
    begin
        op = ecc_pa_pkg::OP_NOP;
        sa = ecc_pa_pkg::SRC_ONE;
        sb = ecc_pa_pkg::SRC_ONE;
        sd = ecc_pa_pkg::SRC_T;
        unique case (state_reg)
            ST_RED_X1:   begin op = ecc_pa_pkg::OP_MUL; sb = ecc_pa_pkg::SRC_X1; sd = ecc_pa_pkg::SRC_X1; end
            ST_RED_Y1:   begin op = ecc_pa_pkg::OP_MUL; sb = ecc_pa_pkg::SRC_Y1; sd = ecc_pa_pkg::SRC_Y1; end
            ST_RED_X2:   begin op = ecc_pa_pkg::OP_MUL; sb = ecc_pa_pkg::SRC_X2; sd = ecc_pa_pkg::SRC_X2; end
            ST_RED_Y2:   begin op = ecc_pa_pkg::OP_MUL; sb = ecc_pa_pkg::SRC_Y2; sd = ecc_pa_pkg::SRC_Y2; end
            ST_RED_A:    begin op = ecc_pa_pkg::OP_MUL; sb = ecc_pa_pkg::SRC_A;  sd = ecc_pa_pkg::SRC_A;  end
            ST_DBL_SQ:   begin op = ecc_pa_pkg::OP_MUL; sa = ecc_pa_pkg::SRC_X1; sb = ecc_pa_pkg::SRC_X1; sd = ecc_pa_pkg::SRC_T; end
            ST_DBL_N1:   begin op = ecc_pa_pkg::OP_ADD; sa = ecc_pa_pkg::SRC_T;   sb = ecc_pa_pkg::SRC_T; sd = ecc_pa_pkg::SRC_NUM; end
            ST_DBL_N2:   begin op = ecc_pa_pkg::OP_ADD; sa = ecc_pa_pkg::SRC_NUM; sb = ecc_pa_pkg::SRC_T; sd = ecc_pa_pkg::SRC_NUM; end
            ST_DBL_N3:   begin op = ecc_pa_pkg::OP_ADD; sa = ecc_pa_pkg::SRC_NUM; sb = ecc_pa_pkg::SRC_A; sd = ecc_pa_pkg::SRC_NUM; end
            ST_DBL_D:    begin op = ecc_pa_pkg::OP_ADD; sa = ecc_pa_pkg::SRC_Y1;  sb = ecc_pa_pkg::SRC_Y1; sd = ecc_pa_pkg::SRC_DEN; end
            ST_CH_N:     begin op = ecc_pa_pkg::OP_SUB; sa = ecc_pa_pkg::SRC_Y2; sb = ecc_pa_pkg::SRC_Y1; sd = ecc_pa_pkg::SRC_NUM; end
            ST_CH_D:     begin op = ecc_pa_pkg::OP_SUB; sa = ecc_pa_pkg::SRC_X2; sb = ecc_pa_pkg::SRC_X1; sd = ecc_pa_pkg::SRC_DEN; end
            ST_INV_INIT: begin op = ecc_pa_pkg::OP_COPY; sa = ecc_pa_pkg::SRC_ONE; sd = ecc_pa_pkg::SRC_ACC; end
            ST_INV_MUL:
            begin
                if (stat.exp_bit)
                begin
                    op = ecc_pa_pkg::OP_MUL; sa = ecc_pa_pkg::SRC_ACC;
                    sb = ecc_pa_pkg::SRC_DEN; sd = ecc_pa_pkg::SRC_ACC;
                end
            end
            ST_INV_SQ:   begin op = ecc_pa_pkg::OP_MUL; sa = ecc_pa_pkg::SRC_DEN; sb = ecc_pa_pkg::SRC_DEN; sd = ecc_pa_pkg::SRC_DEN; end
            ST_SLOPE:    begin op = ecc_pa_pkg::OP_MUL; sa = ecc_pa_pkg::SRC_NUM; sb = ecc_pa_pkg::SRC_ACC; sd = ecc_pa_pkg::SRC_S; end
            ST_X3_SQ:    begin op = ecc_pa_pkg::OP_MUL; sa = ecc_pa_pkg::SRC_S; sb = ecc_pa_pkg::SRC_S; sd = ecc_pa_pkg::SRC_T; end
            ST_X3_S1:    begin op = ecc_pa_pkg::OP_SUB; sa = ecc_pa_pkg::SRC_T; sb = ecc_pa_pkg::SRC_X1; sd = ecc_pa_pkg::SRC_T; end
            ST_X3_S2:    begin op = ecc_pa_pkg::OP_SUB; sa = ecc_pa_pkg::SRC_T; sb = ecc_pa_pkg::SRC_X2; sd = ecc_pa_pkg::SRC_T; end
            ST_Y3_D:     begin op = ecc_pa_pkg::OP_SUB; sa = ecc_pa_pkg::SRC_X1; sb = ecc_pa_pkg::SRC_T; sd = ecc_pa_pkg::SRC_NUM; end
            ST_Y3_M:     begin op = ecc_pa_pkg::OP_MUL; sa = ecc_pa_pkg::SRC_S; sb = ecc_pa_pkg::SRC_NUM; sd = ecc_pa_pkg::SRC_NUM; end
            ST_Y3_S:     begin op = ecc_pa_pkg::OP_SUB; sa = ecc_pa_pkg::SRC_NUM; sb = ecc_pa_pkg::SRC_Y1; sd = ecc_pa_pkg::SRC_NUM; end
            ST_WRITE:    op = stat.mod_small ? ecc_pa_pkg::OP_OUT_ZERO : ecc_pa_pkg::OP_OUT;
            ST_IDLE:     op = ecc_pa_pkg::OP_LOAD;
            default:     op = ecc_pa_pkg::OP_NOP;
        endcase
    end

    // multiplies are issued once and finish on mul_done; other ops do not wait for mul_done
    always_comb
    begin
        cmd.op        = op;
        cmd.src_a     = sa;
        cmd.src_b     = sb;
        cmd.dst       = sd;
        cmd.exp_load  = (state_reg == ST_INV_INIT);
        cmd.exp_shift = (state_reg == ST_INV_SQ) && stat.mul_done;
        step_done     = 1'b1;
        issued_next   = 1'b0;
        if (op == ecc_pa_pkg::OP_MUL)
        begin
            cmd.go      = !issued_reg;
            step_done   = stat.mul_done;
            issued_next = !stat.mul_done;
        end
        else if (state_reg == ST_IDLE)
            cmd.go = in_valid;
        else if (state_reg == ST_WRITE)
            cmd.go = !out_valid_reg || !out_stall;
        else
            cmd.go = 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_CHECK;
            ST_CHECK:    state_next = stat.mod_small ? ST_WRITE : ST_RED_X1;
            ST_RED_X1:   if (step_done) state_next = ST_RED_Y1;
            ST_RED_Y1:   if (step_done) state_next = ST_RED_X2;
            ST_RED_X2:   if (step_done) state_next = ST_RED_Y2;
            ST_RED_Y2:   if (step_done) state_next = ST_RED_A;
            ST_RED_A:    if (step_done) state_next = ST_BRANCH;
            ST_BRANCH:   state_next = stat.same_point ? ST_DBL_SQ : ST_CH_N;
            ST_DBL_SQ:   if (step_done) state_next = ST_DBL_N1;
            ST_DBL_N1:   state_next = ST_DBL_N2;
            ST_DBL_N2:   state_next = ST_DBL_N3;
            ST_DBL_N3:   state_next = ST_DBL_D;
            ST_DBL_D:    state_next = ST_INV_INIT;
            ST_CH_N:     state_next = ST_CH_D;
            ST_CH_D:     state_next = ST_INV_INIT;
            ST_INV_INIT:
            begin
                rnd_next   = '0;
                state_next = ST_INV_MUL;
            end
            ST_INV_MUL:  if (step_done) state_next = ST_INV_SQ;
            ST_INV_SQ:
            begin
                if (step_done)
                begin
                    rnd_next   = rnd_reg + RW'(1);
                    state_next = (rnd_reg == LAST_ROUND) ? ST_SLOPE : ST_INV_MUL;
                end
            end
            ST_SLOPE:    if (step_done) state_next = ST_X3_SQ;
            ST_X3_SQ:    if (step_done) state_next = ST_X3_S1;
            ST_X3_S1:    state_next = ST_X3_S2;
            ST_X3_S2:    state_next = ST_Y3_D;
            ST_Y3_D:     state_next = ST_Y3_M;
            ST_Y3_M:     if (step_done) state_next = ST_Y3_S;
            ST_Y3_S:     state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== sv/ecc_affine_point_add.sv =====
// ----------------------------------------------------------------------------
// ecc_affine_point_add
// affine point addition / doubling over a prime field with fermat inversion
// ----------------------------------------------------------------------------
// work: up to 2*W + 9 serial modular multiplies for W = FIELD_WIDTH, each run one
//   double-and-add step per cycle; zero exponent bits skip their multiply; with a
//   modulus below two the output register is loaded with zeros and no multiply runs
// throughput: one transaction at a time; the next can be taken in the cycle after the
//   result is loaded into the output register, which waits while out_stall holds
// reset: modulus = 2^31 - 1, curve_a = 0, no transaction in flight
`default_nettype none

module ecc_affine_point_add (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire ecc_pa_pkg::in_t                    in_data,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output ecc_pa_pkg::out_t                        out_data,
    // configuration writes
    input  wire logic                               cfg_write,
    input  wire logic                               cfg_index,
    input  wire logic [ecc_pa_pkg::FIELD_WIDTH-1:0] cfg_data
);

    // command and status between sequencer and datapath
    ecc_pa_pkg::cmd_t  cmd;
    ecc_pa_pkg::stat_t stat;

    // sequencer: reduce inputs, pick slope form, run square-and-multiply
    // for d^(p-2), then form x3 and y3 and load the output register
    ecc_pa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath: config registers, working registers, modular add/sub and
    // the serial multiplier (also used with a unit operand to reduce inputs)
    ecc_pa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// ===== bench/tb_ecc_affine_point_add.sv =====
// ----------------------------------------------------------------------------
// tb_ecc_affine_point_add
// self-checking bench for the affine point adder: several modulus and curve
// settings, directed corner points, then random point pairs, each checked
// against an in-bench model of the chord and tangent formulas
// ----------------------------------------------------------------------------

module tb_ecc_affine_point_add;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          W         = ecc_pa_pkg::FIELD_WIDTH;
    localparam logic [W-1:0] ALL_ONES  = '1;
    localparam logic [W-1:0] MERSENNE = 31'h7FFF_FFFF;
    localparam longint      CYCLE_CAP = 40_000_000;
    localparam int          DRAIN     = 3000;

    // ------------------------------------------------------------------------
    // scoreboard: field model plus queue of expected sums
    // ------------------------------------------------------------------------
    class point_sum_board;
        logic [63:0]      field_p;
        logic [63:0]      coef_a;
        ecc_pa_pkg::out_t sums_due[$];
        int               errors;

        function new();
            field_p = 64'(ecc_pa_pkg::MODULUS_RESET);
            coef_a  = 64'(ecc_pa_pkg::CURVE_A_RESET);
            errors  = 0;
        endfunction

        function void set_reg(logic idx, logic [W-1:0] val);
            if (idx == ecc_pa_pkg::CFG_MODULUS)
                field_p = 64'(val);
            else
                coef_a = 64'(val);
        endfunction

        // square and multiply; products stay below 2^62
        function logic [63:0] fermat_pow(logic [63:0] b, logic [63:0] e);
            logic [63:0] acc;
            acc = 64'd1 % field_p;
            b   = b % field_p;
            while (e != 0) begin
                if (e[0])
                    acc = (acc * b) % field_p;
                b = (b * b) % field_p;
                e = e >> 1;
            end
            return acc;
        endfunction

        function ecc_pa_pkg::out_t point_sum(ecc_pa_pkg::in_t d);
            logic [63:0]      m, x1, y1, x2, y2, a, num, den, s, x3, y3;
            ecc_pa_pkg::out_t r;
            m = field_p;
            r = '0;
            if (m < 2)
                return r;
            x1 = 64'(d.point_x1) % m;
            y1 = 64'(d.point_y1) % m;
            x2 = 64'(d.point_x2) % m;
            y2 = 64'(d.point_y2) % m;
            a  = coef_a % m;
            if (x1 == x2 && y1 == y2) begin
                // tangent slope
                num = (3 * ((x1 * x1) % m) + a) % m;
                den = (2 * y1) % m;
            end
            else begin
                // chord slope
                num = (y2 + m - y1) % m;
                den = (x2 + m - x1) % m;
            end
            s  = (num * fermat_pow(den, m - 2)) % m;
            x3 = ((s * s) % m + 2 * m - x1 - x2) % m;
            y3 = ((s * ((x1 + m - x3) % m)) % m + m - y1) % m;
            r.sum_x = x3[W-1:0];
            r.sum_y = y3[W-1:0];
            return r;
        endfunction

        function void note_input(ecc_pa_pkg::in_t d);
            sums_due.push_back(point_sum(d));
        endfunction

        task report(string what, logic [W-1:0] got, logic [W-1:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_sum(ecc_pa_pkg::out_t got);
            ecc_pa_pkg::out_t want;
            if (sums_due.size() == 0) begin
                report("unexpected transaction sum_x", got.sum_x, '0);
                return;
            end
            want = sums_due.pop_front();
            if (got.sum_x !== want.sum_x)
                report("sum_x", got.sum_x, want.sum_x);
            if (got.sum_y !== want.sum_y)
                report("sum_y", got.sum_y, want.sum_y);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    ecc_pa_pkg::in_t  in_data;
    logic             out_valid;
    logic             out_stall;
    ecc_pa_pkg::out_t out_data;
    logic             cfg_write;
    logic             cfg_index;
    logic [W-1:0]     cfg_data;

    point_sum_board board;

    int     send_idle_pct;   // chance of an idle cycle before each offer
    int     recv_stall_pct;  // chance of stall per cycle
    logic   hold_start;      // kicks off a long receiver hold-off
    int     hold_left;
    longint cycles;

    ecc_affine_point_add DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // receiver side: random stalls plus one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= 8000;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        out_stall <= (hold_start || hold_left > 1) ||
                     ($urandom_range(0, 99) < recv_stall_pct);
    end

    // result monitor, samples pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_sum(out_data);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL ecc_affine_point_add");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------
    task drain();
        in_valid <= 1'b0;
        while (board.sums_due.size() != 0)
            @(posedge clk);
    endtask

    // registers change only with nothing in flight
    task write_reg(logic idx, logic [W-1:0] val);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_reg(idx, val);
    endtask

    // random idle cycles, then offer one point pair and hold it until taken
    task send_points(ecc_pa_pkg::in_t d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(d);
    endtask

    function logic [W-1:0] pick_coord();
        logic [63:0] p;
        int          k;
        p = board.field_p;
        k = $urandom_range(0, 99);
        if (k < 8)
            return '0;
        else if (k < 14)
            return ALL_ONES;
        else if (k < 24 || p < 2)
            return W'($urandom());             // often unreduced
        else
            return W'($urandom_range(0, 32'(p - 1)));
    endfunction

    function ecc_pa_pkg::in_t pick_points();
        ecc_pa_pkg::in_t d;
        int              k;
        d.point_x1 = pick_coord();
        d.point_y1 = pick_coord();
        d.point_x2 = pick_coord();
        d.point_y2 = pick_coord();
        k = $urandom_range(0, 99);
        if (k < 30) begin
            // doubling
            d.point_x2 = d.point_x1;
            d.point_y2 = d.point_y1;
        end
        else if (k < 40)
            d.point_x2 = d.point_x1;             // vertical chord
        return d;
    endfunction

    task run_random(int count, int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
        repeat (count)
            send_points(pick_points());
        drain();
    endtask

    function ecc_pa_pkg::in_t pts(logic [W-1:0] x1, logic [W-1:0] y1,
                                  logic [W-1:0] x2, logic [W-1:0] y2);
        ecc_pa_pkg::in_t d;
        d.point_x1 = x1;
        d.point_y1 = y1;
        d.point_x2 = x2;
        d.point_y2 = y2;
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        board          = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_write      = 1'b0;
        cfg_index      = ecc_pa_pkg::CFG_MODULUS;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_start     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed points at the reset curve
        send_points(pts(0, 0, 0, 0));                        // doubling, zero denominator
        send_points(pts(1, 2, 1, 2));                        // plain doubling
        send_points(pts(5, 7, 5, 9));                        // vertical chord
        send_points(pts(1, 1, 2, 2));                        // chord
        send_points(pts(MERSENNE - 1, MERSENNE - 1, 0, 0));  // field extremes
        send_points(pts(MERSENNE - 1, 3, MERSENNE - 1, 3));
        send_points(pts(ALL_ONES, 3, 0, 3));                 // unreduced equals reduced
        send_points(pts(ALL_ONES, ALL_ONES, 0, 0));
        send_points(pts(12345, 67890, 424242, 99));
        drain();

        write_reg(ecc_pa_pkg::CFG_CURVE_A, MERSENNE - 1);
        send_points(pts(3, 4, 3, 4));
        send_points(pts(MERSENNE - 1, 1, MERSENNE - 1, 1));
        write_reg(ecc_pa_pkg::CFG_CURVE_A, ALL_ONES);        // unreduced coefficient
        send_points(pts(3, 4, 3, 4));
        drain();

        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd97);
        write_reg(ecc_pa_pkg::CFG_CURVE_A, 31'd5);
        send_points(pts(3, 6, 3, 6));
        send_points(pts(100, 200, 3, 9));                    // unreduced inputs
        send_points(pts(97, 0, 0, 97));                      // reduce to the same point
        drain();

        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd0);           // degenerate moduli
        send_points(pts(9, 9, 9, 9));
        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd1);
        send_points(pts(ALL_ONES, 1, 2, 3));
        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd2);           // zero exponent
        send_points(pts(1, 1, 1, 1));
        send_points(pts(0, 1, 1, 0));
        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd15);          // not prime
        send_points(pts(4, 7, 4, 7));
        send_points(pts(2, 3, 11, 13));
        drain();

        // random phases across curve settings and idling patterns
        write_reg(ecc_pa_pkg::CFG_MODULUS, MERSENNE);
        write_reg(ecc_pa_pkg::CFG_CURVE_A, '0);
        run_random(250, 0);

        write_reg(ecc_pa_pkg::CFG_CURVE_A, 31'h2AAA_AAAA);
        // long receiver hold-off while the sender keeps offering
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        run_random(250, 2);

        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd3);
        write_reg(ecc_pa_pkg::CFG_CURVE_A, 31'd2);
        run_random(150, 1);

        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd65521);
        write_reg(ecc_pa_pkg::CFG_CURVE_A, 31'd7);
        run_random(250, 3);

        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd2147483629);
        write_reg(ecc_pa_pkg::CFG_CURVE_A, 31'd2147483628);
        run_random(250, 0);

        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd97);
        write_reg(ecc_pa_pkg::CFG_CURVE_A, 31'd0);
        run_random(150, 2);

        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd2);
        write_reg(ecc_pa_pkg::CFG_CURVE_A, 31'd1);
        run_random(50, 3);

        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd1);
        run_random(30, 0);

        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd21);
        write_reg(ecc_pa_pkg::CFG_CURVE_A, 31'd30);
        run_random(70, 1);

        write_reg(ecc_pa_pkg::CFG_MODULUS, MERSENNE);
        write_reg(ecc_pa_pkg::CFG_CURVE_A, 31'd3);
        run_random(280, 3);

        write_reg(ecc_pa_pkg::CFG_MODULUS, 31'd1000003);
        write_reg(ecc_pa_pkg::CFG_CURVE_A, ALL_ONES);
        run_random(250, 0);

        // let anything still inside settle
        repeat (DRAIN) @(posedge clk);
        if (board.errors == 0 && board.sums_due.size() == 0)
            $display("PASS ecc_affine_point_add");
        else
            $display("FAIL ecc_affine_point_add");
        $finish;
    end

endmodule
